### src/byte_ring_fifo_drop_oldest_assert.svh
// assertion macros shared by the rtl
`ifndef BYTE_RING_FIFO_DROP_OLDEST_ASSERT_SVH
`define BYTE_RING_FIFO_DROP_OLDEST_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define BRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define BRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BRF_ASSERT(lbl, prop, msg)
`define BRF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/brfifo_pkg.sv
package brfifo_pkg;

  localparam int CntW     = 11;
  localparam int ByteW    = 8;
  localparam int OpW      = 3;
  localparam int StW      = 2;
  localparam int DataW    = 32;
  localparam int PaddrW   = 3;
  localparam int PlanCap  = 256;
  localparam int CapReset = 1024;
  localparam int ChunkReset = 1;
  // one remainder bit per dividend bit
  localparam int DivSteps = CntW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [OpW-1:0] {
    OpClear   = 3'd0,
    OpReserve = 3'd1,
    OpPush    = 3'd2,
    OpCheck   = 3'd3,
    OpPop     = 3'd4,
    OpPlan    = 3'd5
  } op_e;

  typedef enum logic [StW-1:0] {
    StOk   = 2'd0,
    StFew  = 2'd1,
    StFull = 2'd2,
    StOver = 2'd3
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [CntW-1:0]  length;
    logic [ByteW-1:0] data_byte;
    logic [CntW-1:0]  stream_free;
    logic [CntW-1:0]  max_len;
  } in_item_t;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic [ByteW-1:0] read_byte;
    logic [CntW-1:0]  count;
    logic [CntW-1:0]  bytes_used;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0]  cap_eff;
    logic [ByteW-1:0] chunk_eff;
    logic             clear;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic div_step;
    logic apply;
    logic adjust;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic            need_div;
    logic            is_plan;
    logic            div_last;
    logic [CntW-1:0] fill;
  } dp_sts_t;

endpackage

### src/brfifo_regs.sv
module brfifo_regs import brfifo_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  typedef enum logic {
    RegCapacity = 1'b0,
    RegChunk    = 1'b1
  } reg_e;

  logic [CntW-1:0]  capacity_q, capacity_d;
  logic [ByteW-1:0] chunk_q, chunk_d;
  logic             wr_en;
  reg_e             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    capacity_d  = capacity_q;
    chunk_d     = chunk_q;
    prdata      = '0;
    unique case (reg_sel)
      RegCapacity: begin
        prdata = DataW'(capacity_q);
        if (wr_en) begin
          capacity_d  = pwdata[CntW-1:0];
        end
      end
      RegChunk: begin
        prdata = DataW'(chunk_q);
        if (wr_en) begin
          chunk_d = pwdata[ByteW-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CntW'(CapReset);
      chunk_q    <= ByteW'(ChunkReset);
    end else begin
      capacity_q <= capacity_d;
      chunk_q    <= chunk_d;
    end
  end

  // zero counts as one, above the store counts as the store
  always_comb begin
    if (capacity_q == '0) begin
      cfg_o.cap_eff = CntW'(1);
    end else if (32'(capacity_q) > DEPTH) begin
      cfg_o.cap_eff = CntW'(DEPTH);
    end else begin
      cfg_o.cap_eff = capacity_q;
    end
    cfg_o.chunk_eff = (chunk_q == '0) ? ByteW'(1) : chunk_q;
    // a capacity write empties the buffer
    cfg_o.clear     = wr_en && (reg_sel == RegCapacity);
  end

endmodule

### src/brfifo_ctrl.sv
module brfifo_ctrl import brfifo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_DIV   = 6'b000100,
    S_APPLY = 6'b001000,
    S_ADJ   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.is_plan ? S_DONE : S_ADJ;
      end
      S_ADJ: begin
        cmd_o.adjust = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/brfifo_dp.sv
module brfifo_dp import brfifo_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  cfg_t      cfg_i,
  input  in_item_t  in_item_i,
  output dp_sts_t   sts_o,
  output out_item_t out_item_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int SumW = ((AW > CntW) ? AW : CntW) + 1;

  logic [ByteW-1:0] mem [DEPTH];

  in_item_t         in_q;
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [ByteW-1:0] rdata_q;
  logic             mem_we;

  // remainder unit
  logic [CntW-1:0]    opnd_q, dvd_q;
  logic [ByteW-1:0]   rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic [ByteW:0]     rem_try;
  logic               rem_ge;

  logic [CntW-1:0] gone_q, gone_d;
  out_item_t       res_q, res_d, out_q;

  op_e             op;
  logic [CntW-1:0] cap, room, need, plan_m, div_src;
  logic [ByteW-1:0] chunk;
  logic            len_over, need_drop;
  logic [SumW-1:0] wp_inc, rp_inc, rp_sum;
  logic [AW-1:0]   wp_next, rp_next, rp_adj;
  logic [CntW:0]   rounded;
  logic [CntW-1:0] plan_mr, plan_c1, plan_cnt;

  assign op    = op_e'(in_q.opcode);
  assign cap   = cfg_i.cap_eff;
  assign chunk = cfg_i.chunk_eff;

  assign room      = cap - fill_q;
  assign len_over  = in_q.length > cap;
  assign need_drop = room < in_q.length;
  assign need      = in_q.length - room;
  assign plan_m    = (32'(in_q.max_len) > PlanCap) ? CntW'(PlanCap) : in_q.max_len;
  assign div_src   = (op == OpPlan) ? plan_m : need;

  // single step wrap of both pointers
  assign wp_inc  = SumW'(wp_q) + SumW'(1);
  assign rp_inc  = SumW'(rp_q) + SumW'(1);
  assign wp_next = (wp_inc >= SumW'(cap)) ? '0 : AW'(wp_inc);
  assign rp_next = (rp_inc >= SumW'(cap)) ? '0 : AW'(rp_inc);
  // drop advance, sum stays below twice the capacity
  assign rp_sum  = SumW'(rp_q) + SumW'(gone_q);
  assign rp_adj  = (rp_sum >= SumW'(cap)) ? AW'(rp_sum - SumW'(cap)) : AW'(rp_sum);

  // round the shortfall up to whole chunks, capped at what is stored
  assign rounded  = (CntW+1)'(opnd_q) - (CntW+1)'(rem_q)
                  + ((rem_q != '0) ? (CntW+1)'(chunk) : '0);
  assign plan_mr  = opnd_q - CntW'(rem_q);
  assign plan_c1  = (in_q.stream_free < plan_mr) ? in_q.stream_free : plan_mr;
  assign plan_cnt = (fill_q < plan_c1) ? fill_q : plan_c1;

  assign rem_try = {rem_q, dvd_q[CntW-1]};
  assign rem_ge  = rem_try >= (ByteW+1)'(chunk);

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    fill_d = fill_q;
    mem_we = 1'b0;
    res_d  = res_q;
    gone_d = gone_q;
    if (cfg_i.clear) begin
      wp_d   = '0;
      rp_d   = '0;
      fill_d = '0;
    end else if (cmd_i.exec) begin
      res_d.status    = StOk;
      res_d.read_byte = '0;
      res_d.count     = '0;
      case (op)
        OpClear: begin
          wp_d   = '0;
          rp_d   = '0;
          fill_d = '0;
        end
        OpReserve: begin
          if (len_over) begin
            res_d.status = StOver;
          end
        end
        OpPush: begin
          if (fill_q >= cap) begin
            res_d.status = StFull;
          end else begin
            mem_we = 1'b1;
            wp_d   = wp_next;
            fill_d = fill_q + CntW'(1);
          end
        end
        OpCheck: begin
          if (fill_q < in_q.length) begin
            res_d.status = StFew;
          end
        end
        OpPop: begin
          if (fill_q == '0) begin
            res_d.status = StFew;
          end else begin
            res_d.read_byte = rdata_q;
            rp_d            = rp_next;
            fill_d          = fill_q - CntW'(1);
          end
        end
        default: ;
      endcase
      res_d.bytes_used = fill_d;
    end else if (cmd_i.apply) begin
      if (op == OpPlan) begin
        res_d.count = plan_cnt;
      end else begin
        gone_d      = (rounded > (CntW+1)'(fill_q)) ? fill_q : rounded[CntW-1:0];
        res_d.count = gone_d;
      end
    end else if (cmd_i.adjust) begin
      rp_d             = rp_adj;
      fill_d           = fill_q - gone_q;
      res_d.bytes_used = fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  // store, read ahead at the next read position
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= in_q.data_byte;
    end
    rdata_q <= mem[rp_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      opnd_q <= div_src;
      dvd_q  <= div_src;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? ByteW'(rem_try - (ByteW+1)'(chunk)) : rem_try[ByteW-1:0];
      dvd_q  <= dvd_q << 1;
      cnt_q  <= cnt_q + DivCntW'(1);
    end
    gone_q <= gone_d;
    res_q  <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign sts_o.need_div = ((op == OpReserve) && !len_over && need_drop) || (op == OpPlan);
  assign sts_o.is_plan  = (op == OpPlan);
  assign sts_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));
  assign sts_o.fill     = fill_q;
  assign out_item_o     = out_q;

endmodule

### src/byte_ring_fifo_drop_oldest.sv
// Byte ring buffer with an overwrite-oldest reserve. Items come in one at a
// time on a valid/stall channel and each gives exactly one result item. Clear,
// push, pop, remove-check, reserve without a drop and unused opcodes pass
// through accept, execute and hand-off on their way to the result register.
// Reserve that must drop bytes and plan both pass through one shared restoring
// remainder unit that works one dividend bit per cycle over the 11-bit length,
// then an apply step rounds and caps the count and, for reserve, an adjust
// step moves the read pointer. The result sits in its own output register,
// so the next item is taken while the previous one still waits to be
// collected. The store is a single-port-write memory of DEPTH bytes with
// a registered read; it is not cleared after reset and a pop only
// ever reads bytes that were pushed. The APB port holds capacity (address 0)
// and drop_chunk (address 4); writing capacity empties the buffer. Write
// registers only while the block is idle.

`include "byte_ring_fifo_drop_oldest_assert.svh"

module byte_ring_fifo_drop_oldest import brfifo_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // capacity and chunk registers, clamped to usable values
  brfifo_regs #(
    .DEPTH (DEPTH)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one item in flight, hands results to the output register
  brfifo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // pointers, fill level, byte store, remainder unit and result registers
  brfifo_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_item_i  (in_item_i),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

  // fill level never runs past the capacity in use
  `BRF_ASSERT(a_fill_within_cap, sts.fill <= cfg.cap_eff, "fill level above capacity")

  // one item at a time: the input is held off right after an accept
  `BRF_ASSERT(a_stall_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "second item taken while busy")

  // a fresh result reports the fill level the buffer really has
  `BRF_ASSERT(a_used_matches_fill, $rose(out_valid_o) |-> out_item_o.bytes_used == sts.fill, "bytes_used disagrees with fill level")

endmodule

### test/byte_ring_fifo_drop_oldest_tb.sv
module byte_ring_fifo_drop_oldest_tb;
  import brfifo_pkg::*;

  localparam int RingDepth = 1024;
  // cycles without any item moving before the run is declared hung
  localparam int IdleLimit = 3000;
  // cycles allowed after the last result for stray output items
  localparam int TailCycles = 40;
  localparam int RandomItems = 1026;

  // register map
  localparam logic [PaddrW-1:0] AddrCapacity  = 3'd0;
  localparam logic [PaddrW-1:0] AddrDropChunk = 3'd4;

  // opcodes with no function, expected to act as no-ops
  localparam logic [OpW-1:0] OpSpareA = 3'd6;
  localparam logic [OpW-1:0] OpSpareB = 3'd7;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [DataW-1:0]  pwdata  = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  byte_ring_fifo_drop_oldest #(
    .DEPTH(RingDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // handshakes as seen just before each rising edge
  wire took_in  = in_valid & ~in_stall;
  wire took_out = out_valid & ~out_stall;

  in_item_t  ops_to_send [$];
  out_item_t results_due [$];

  int errors      = 0;
  int idle_cycles = 0;
  int result_idx  = 0;
  int send_gap    = 0;
  int recv_hold   = 0;
  // when set, neither side inserts gaps or stalls
  bit calm        = 1'b0;

  // shadow of the ring: register copies, byte store, pointers and fill level
  logic [CntW-1:0]  cap_cfg   = CntW'(CapReset);
  logic [ByteW-1:0] chunk_cfg = ByteW'(ChunkReset);
  logic [ByteW-1:0] ring_mem [RingDepth];
  int unsigned      wr_at     = 0;
  int unsigned      rd_at     = 0;
  int unsigned      held      = 0;

  // capacity zero behaves as one, anything above the store as the full store
  function automatic int unsigned cap_eff();
    if (cap_cfg == 0) return 1;
    if (cap_cfg > RingDepth) return RingDepth;
    return cap_cfg;
  endfunction

  function automatic void ring_empty();
    wr_at = 0;
    rd_at = 0;
    held  = 0;
  endfunction

  // expected result of one item, advancing the shadow ring
  function automatic out_item_t ring_apply(in_item_t it);
    int unsigned cap, chunk, room, need, gone, lim;
    out_item_t   r;
    cap   = cap_eff();
    chunk = (chunk_cfg == 0) ? 1 : chunk_cfg;
    r     = '0;
    case (it.opcode)
      OpClear: ring_empty();
      OpReserve: begin
        if (it.length > cap) begin
          r.status = StOver;
        end else begin
          room = cap - held;
          if (room < it.length) begin
            // drop whole chunks, never more than is stored
            need = it.length - room;
            gone = ((need + chunk - 1) / chunk) * chunk;
            if (gone > held) gone = held;
            rd_at += gone;
            if (rd_at >= cap) rd_at -= cap;
            held   -= gone;
            r.count = CntW'(gone);
          end
        end
      end
      OpPush: begin
        if (held >= cap) begin
          r.status = StFull;
        end else begin
          ring_mem[wr_at] = it.data_byte;
          wr_at = (wr_at + 1 >= cap) ? 0 : wr_at + 1;
          held++;
        end
      end
      OpCheck: begin
        if (held < it.length) r.status = StFew;
      end
      OpPop: begin
        if (held == 0) begin
          r.status = StFew;
        end else begin
          r.read_byte = ring_mem[rd_at];
          rd_at = (rd_at + 1 >= cap) ? 0 : rd_at + 1;
          held--;
        end
      end
      OpPlan: begin
        // cap the request, round down to the chunk, then bound by stream and fill
        lim = (it.max_len > PlanCap) ? PlanCap : it.max_len;
        lim -= lim % chunk;
        if (it.stream_free < lim) lim = it.stream_free;
        if (held < lim) lim = held;
        r.count = CntW'(lim);
      end
      default: ;
    endcase
    r.bytes_used = CntW'(held);
    return r;
  endfunction

  function automatic int pause_len();
    if (calm) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  // sender: presents queued items, draws a gap after each accepted one
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (took_in) begin
        results_due.push_back(ring_apply(in_item));
        send_gap = pause_len();
      end
      if (!in_valid || took_in) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          in_item  <= ops_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compares each result with the oldest expectation, then stalls a while
  always @(posedge clk_i) begin : collect
    out_item_t want;
    if (rst_n) begin
      if (took_out) begin
        if (results_due.size() == 0) begin
          flag_error($sformatf("result %0d arrived with none expected", result_idx));
        end else begin
          want = results_due.pop_front();
          if (out_item.status !== want.status)
            flag_error($sformatf("result %0d status %0d, want %0d",
                                 result_idx, out_item.status, want.status));
          if (out_item.read_byte !== want.read_byte)
            flag_error($sformatf("result %0d read_byte %0h, want %0h",
                                 result_idx, out_item.read_byte, want.read_byte));
          if (out_item.count !== want.count)
            flag_error($sformatf("result %0d count %0d, want %0d",
                                 result_idx, out_item.count, want.count));
          if (out_item.bytes_used !== want.bytes_used)
            flag_error($sformatf("result %0d bytes_used %0d, want %0d",
                                 result_idx, out_item.bytes_used, want.bytes_used));
        end
        result_idx++;
        recv_hold = pause_len();
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // hang detection: counts cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (took_in || took_out) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic queue_op(logic [OpW-1:0] op, int length, int data, int sfree, int mlen);
    in_item_t it;
    it.opcode      = op;
    it.length      = CntW'(length);
    it.data_byte   = ByteW'(data);
    it.stream_free = CntW'(sfree);
    it.max_len     = CntW'(mlen);
    ops_to_send.push_back(it);
  endtask

  // random items with a push-heavy mix so the ring fills, wraps and overflows
  task automatic queue_random(int n);
    in_item_t    it;
    int          pick;
    int unsigned cap, hi;
    cap = cap_eff();
    hi  = (cap < RingDepth) ? cap + 1 : RingDepth;
    for (int i = 0; i < n; i++) begin
      it.length      = CntW'($urandom_range(0, 1024));
      it.data_byte   = ByteW'($urandom);
      it.stream_free = CntW'($urandom_range(0, 1024));
      it.max_len     = CntW'($urandom_range(0, 1024));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        it.opcode = OpPush;
      end else if (pick < 60) begin
        it.opcode = OpPop;
      end else if (pick < 74) begin
        it.opcode = OpReserve;
        // mostly lengths from zero up to one past the capacity
        if ($urandom_range(0, 3) != 0) it.length = CntW'($urandom_range(0, hi));
      end else if (pick < 84) begin
        it.opcode = OpCheck;
        if ($urandom_range(0, 3) != 0) it.length = CntW'($urandom_range(0, cap));
      end else if (pick < 94) begin
        it.opcode = OpPlan;
        if ($urandom_range(0, 1) != 0) it.max_len = CntW'($urandom_range(0, 300));
        if ($urandom_range(0, 1) != 0) it.stream_free = CntW'($urandom_range(0, 64));
      end else if (pick < 97) begin
        it.opcode = OpClear;
      end else begin
        it.opcode = $urandom_range(0, 1) ? OpSpareA : OpSpareB;
      end
      ops_to_send.push_back(it);
    end
  endtask

  // wait until every queued item has gone in and every result has come out
  task automatic settle();
    do @(negedge clk_i);
    while (ops_to_send.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  // setup then access phase; the shadow registers follow once the write lands
  task automatic reg_write(logic [PaddrW-1:0] addr, logic [DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrCapacity) begin
      cap_cfg = CntW'(val);
      ring_empty();
    end else if (addr == AddrDropChunk) begin
      chunk_cfg = ByteW'(val);
    end
    @(negedge clk_i);
  endtask

  // register settings for the random phases: zero, one, odd sizes, oversize, full store
  int cap_steps   [8] = '{1, 0, 7, 2047, 16, 1024, 100, 5};
  int chunk_steps [8] = '{1, 0, 3, 255, 255, 5, 1, 4};

  initial begin
    int per_phase;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    // reset settings: empty corner cases, field extremes, a drop on reserve
    queue_op(OpPop, 0, 0, 0, 0);
    queue_op(OpCheck, 0, 0, 0, 0);
    queue_op(OpCheck, 1024, 0, 0, 0);
    queue_op(OpPlan, 0, 0, 1024, 1024);
    queue_op(OpPush, 0, 8'h00, 0, 0);
    queue_op(OpPush, 0, 8'hff, 0, 0);
    queue_op(OpPush, 0, 8'ha5, 0, 0);
    queue_op(OpPlan, 0, 0, 1, 1024);
    queue_op(OpReserve, 1024, 0, 0, 0);
    queue_op(OpSpareA, 1024, 8'hff, 1024, 1024);
    queue_op(OpPush, 0, 8'h5a, 0, 0);
    queue_op(OpPop, 0, 0, 0, 0);
    queue_op(OpClear, 1024, 8'hff, 1024, 1024);
    // leave bytes behind so the capacity write has something to empty
    queue_op(OpPush, 0, 8'h3c, 0, 0);
    queue_op(OpPush, 0, 8'hc3, 0, 0);
    settle();

    // tiny ring with chunk two: full, over-capacity reserve, chunked drop, wrap
    reg_write(AddrCapacity, 3);
    reg_write(AddrDropChunk, 2);
    queue_op(OpPop, 0, 0, 0, 0);
    queue_op(OpPush, 0, 8'h11, 0, 0);
    queue_op(OpPush, 0, 8'h22, 0, 0);
    queue_op(OpPush, 0, 8'h33, 0, 0);
    queue_op(OpPush, 0, 8'h44, 0, 0);
    queue_op(OpReserve, 4, 0, 0, 0);
    queue_op(OpReserve, 3, 0, 0, 0);
    queue_op(OpPush, 0, 8'h55, 0, 0);
    queue_op(OpPlan, 0, 0, 1024, 3);
    queue_op(OpPop, 0, 0, 0, 0);
    settle();

    per_phase = RandomItems / 8;
    for (int p = 0; p < 8; p++) begin
      reg_write(AddrDropChunk, chunk_steps[p]);
      reg_write(AddrCapacity, cap_steps[p]);
      calm = (p % 3 == 2);
      // the sender holds off halfway until the block has drained
      queue_random(per_phase / 2);
      settle();
      queue_random(per_phase - per_phase / 2);
      settle();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
